// File: src/llmt_pkg.sv
// ----------------------------------------------------------------------------
// llmt_pkg - shared types and constants for the map tile converter
// Fixed-point constants, CORDIC angle tables and the data carried between
// the cells of the conversion pipeline.
// ----------------------------------------------------------------------------
package llmt_pkg;

  // Field widths and limits
  localparam int MAX_ZOOM  = 24;
  localparam int FRAC_BITS = 22;
  localparam int LAT_W     = 30;
  localparam int LON_W     = 31;
  localparam int ZOOM_W    = 5;
  localparam int OUT_W     = 24;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  // CORDIC datapath (Q40)
  localparam int WQ     = 40;
  localparam int NIT    = 40;
  localparam int CW     = 48;
  localparam int HYP_N  = 43;
  localparam int NORM_N = 6;
  localparam int SH_W   = 6;
  localparam int K_W    = 7;
  localparam int HD_W   = 34;
  localparam int RR_W   = 44;
  localparam int CR_W   = 32;
  localparam int LA_W   = LAT_W + 22 - FRAC_BITS;
  localparam int P_W    = LA_W + HD_W;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  localparam logic signed [CW-1:0] ONE_Q40 = CW'(64'd1 << WQ);
  localparam logic signed [CW-1:0] PI_Q40  = CW'((PI_Q60 + (64'd1 << 19)) >> 20);
  localparam logic signed [CW-1:0] LN2_Q40 = CW'((LN2_Q64 + (64'd1 << 23)) >> 24);
  localparam logic [RR_W-1:0] ROW_D =
    RR_W'(((PI_Q60 + (64'd1 << 19)) >> 20) << 1);
  localparam logic [HD_W-1:0] HALF_DEG = HD_W'((PI_Q60 / 64'd360) >> 20);
  localparam logic [CR_W-1:0] COL_D    = CR_W'(64'd360 << FRAC_BITS);

  // Sideband that travels with every item
  typedef struct packed {
    logic              north;
    logic              psat;
    logic              zero;
    logic [ZOOM_W-1:0] zoom;
    logic [CR_W-1:0]   col_r;
  } side_t;

  // Circular rotation state
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] a;
  } circ_t;

  // Normalization state, u = X+Y1 lane and w = X-Y1 lane
  typedef struct packed {
    logic [CW-1:0]         vu;
    logic [CW-1:0]         vw;
    logic signed [K_W-1:0] ku;
    logic signed [K_W-1:0] kw;
    logic                  beyond;
    logic                  upos;
  } norm_t;

  // Hyperbolic vectoring state for both log lanes
  typedef struct packed {
    logic signed [CW-1:0]  xu;
    logic signed [CW-1:0]  yu;
    logic signed [CW-1:0]  zu;
    logic signed [CW-1:0]  xw;
    logic signed [CW-1:0]  yw;
    logic signed [CW-1:0]  zw;
    logic signed [K_W-1:0] ku;
    logic signed [K_W-1:0] kw;
    logic                  beyond;
    logic                  upos;
  } ln_t;

  // Restoring division state for row and column
  typedef struct packed {
    logic [RR_W-1:0]  row_r;
    logic [OUT_W-1:0] row_q;
    logic             row_fix;
    logic             sat;
    logic [CR_W-1:0]  col_r;
    logic [OUT_W-1:0] col_q;
  } div_t;

  // atan(2^-i) in Q40, summed from its series in Q60
  function automatic logic signed [CW-1:0] atan_q40(input int i);
    logic signed [63:0] sa;
    logic signed [63:0] t;
    int e;
    int k;
    sa = '0;
    if (i == 0) begin
      return CW'(((PI_Q60 >> 2) + (64'd1 << 19)) >> 20);
    end
    for (k = 0; k < 31; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        t = signed'((64'd1 << (60 - e)) / 64'(2 * k + 1));
        if (k % 2 == 1) sa = sa - t;
        else sa = sa + t;
      end
    end
    return CW'((sa + 64'sd524288) >>> 20);
  endfunction

  // atanh(2^-i) in Q40
  function automatic logic signed [CW-1:0] atanh_q40(input int i);
    logic signed [63:0] sh;
    int e;
    int k;
    sh = '0;
    if (i == 0) begin
      return '0;
    end
    for (k = 0; k < 31; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        sh = sh + signed'((64'd1 << (60 - e)) / 64'(2 * k + 1));
      end
    end
    return CW'((sh + 64'sd524288) >>> 20);
  endfunction

  // Shift of hyperbolic cell j; steps 4, 13 and 40 run twice
  function automatic int hyp_shift(input int j);
    int c;
    int i;
    int r;
    int res;
    c   = 0;
    res = 1;
    for (i = 1; i <= NIT; i++) begin
      for (r = 0; r < 2; r++) begin
        if (r == 0 || i == 4 || i == 13 || i == 40) begin
          if (c == j) res = i;
          c++;
        end
      end
    end
    return res;
  endfunction

endpackage

// File: src/llmt_circ_cell.sv
// ----------------------------------------------------------------------------
// llmt_circ_cell - one circular CORDIC rotation step
// Rotates (x, y) toward the residual angle by atan(2^-shift) and passes the
// result and the item sideband to the next cell.
// ----------------------------------------------------------------------------
module llmt_circ_cell import llmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [SH_W-1:0]      shift,
  input  logic signed [CW-1:0] angle,
  input  logic                 vld_in,
  input  side_t                side_in,
  input  circ_t                cin,
  output logic                 vld_out,
  output side_t                side_out,
  output circ_t                cout
);

  logic signed [CW-1:0] x, y, a, dx, dy;
  circ_t nxt;

  // rotation step, positive direction when residual is non-negative
  always_comb begin
    x  = cin.x;
    y  = cin.y;
    a  = cin.a;
    dx = y >>> shift;
    dy = x >>> shift;
    if (a >= 0) begin
      nxt.x = x - dx;
      nxt.y = y + dy;
      nxt.a = a - angle;
    end else begin
      nxt.x = x + dx;
      nxt.y = y - dy;
      nxt.a = a + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      cout     <= nxt;
    end
  end

endmodule

// File: src/llmt_norm_cell.sv
// ----------------------------------------------------------------------------
// llmt_norm_cell - one step of the leading-zero normalization
// Shifts each lane left by amount when its top amount bits, counting down from
// bit 40, are clear, and lowers its exponent to match.
// ----------------------------------------------------------------------------
module llmt_norm_cell import llmt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [SH_W-1:0] amount,
  input  logic            vld_in,
  input  side_t           side_in,
  input  norm_t           nin,
  output logic            vld_out,
  output side_t           side_out,
  output norm_t           nout
);

  norm_t nxt;

  always_comb begin
    nxt = nin;
    if ((nin.vu[WQ:0] >> (WQ + 1 - int'(amount))) == '0) begin
      nxt.vu = nin.vu << amount;
      nxt.ku = nin.ku - K_W'(amount);
    end
    if ((nin.vw[WQ:0] >> (WQ + 1 - int'(amount))) == '0) begin
      nxt.vw = nin.vw << amount;
      nxt.kw = nin.kw - K_W'(amount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      nout     <= nxt;
    end
  end

endmodule

// File: src/llmt_hyp_cell.sv
// ----------------------------------------------------------------------------
// llmt_hyp_cell - one hyperbolic vectoring step on both log lanes
// Drives y toward zero and accumulates atanh(2^-shift) in z.
// ----------------------------------------------------------------------------
module llmt_hyp_cell import llmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [SH_W-1:0]      shift,
  input  logic signed [CW-1:0] angle,
  input  logic                 vld_in,
  input  side_t                side_in,
  input  ln_t                  hin,
  output logic                 vld_out,
  output side_t                side_out,
  output ln_t                  hout
);

  logic signed [CW-1:0] xu, yu, zu, xw, yw, zw;
  logic signed [CW-1:0] dxu, dyu, dxw, dyw;
  ln_t nxt;

  always_comb begin
    xu  = hin.xu;
    yu  = hin.yu;
    zu  = hin.zu;
    xw  = hin.xw;
    yw  = hin.yw;
    zw  = hin.zw;
    dxu = yu >>> shift;
    dyu = xu >>> shift;
    dxw = yw >>> shift;
    dyw = xw >>> shift;
    nxt = hin;
    // u lane
    if (yu >= 0) begin
      nxt.xu = xu - dxu;
      nxt.yu = yu - dyu;
      nxt.zu = zu + angle;
    end else begin
      nxt.xu = xu + dxu;
      nxt.yu = yu + dyu;
      nxt.zu = zu - angle;
    end
    // w lane
    if (yw >= 0) begin
      nxt.xw = xw - dxw;
      nxt.yw = yw - dyw;
      nxt.zw = zw + angle;
    end else begin
      nxt.xw = xw + dxw;
      nxt.yw = yw + dyw;
      nxt.zw = zw - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      hout     <= nxt;
    end
  end

endmodule

// File: src/llmt_div_cell.sv
// ----------------------------------------------------------------------------
// llmt_div_cell - one restoring division step for row and column
// One quotient bit per lane while step < zoom; a clamped row gets none.
// ----------------------------------------------------------------------------
module llmt_div_cell import llmt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [ZOOM_W-1:0] step,
  input  logic              vld_in,
  input  side_t             side_in,
  input  div_t              din,
  output logic              vld_out,
  output side_t             side_out,
  output div_t              dout
);

  logic [RR_W-1:0] rr;
  logic [CR_W-1:0] cr;
  div_t nxt;

  always_comb begin
    nxt = din;
    rr  = din.row_r << 1;
    cr  = din.col_r << 1;
    if (step < side_in.zoom) begin
      // column lane
      nxt.col_q = din.col_q << 1;
      nxt.col_r = cr;
      if (cr >= COL_D) begin
        nxt.col_r    = cr - COL_D;
        nxt.col_q[0] = 1'b1;
      end
      // row lane, skipped once the row is clamped
      if (!din.row_fix) begin
        nxt.row_q = din.row_q << 1;
        nxt.row_r = rr;
        if (rr >= ROW_D) begin
          nxt.row_r    = rr - ROW_D;
          nxt.row_q[0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      dout     <= nxt;
    end
  end

endmodule

// File: src/lat_long_to_map_tile_top.sv
// ----------------------------------------------------------------------------
// lat_long_to_map_tile_top - Web Mercator tile index from latitude/longitude
// Input transactions carry latitude, longitude and zoom on the slave side;
// output transactions carry tile column, tile row and the saturation flag.
// A new transaction is accepted every clock cycle while s_tready is high;
// the path from input acceptance to m_tvalid is made of the cell chain:
// 2 front stages, 41 circular CORDIC cells, 1 sum stage, 6 normalization
// cells, 43 hyperbolic cells for the two logarithms, 3 combine stages,
// 24 division cells and the output register.
// Reset clears all valid bits; no output is presented until new input.
// The whole pipeline advances together. When the receiver stalls, one
// more result is caught in a skid register; only once it is occupied does
// s_tready drop and the pipeline hold. Items are never dropped or
// reordered. Zoom above 24 is treated as 24; latitudes at or beyond the
// Mercator limits clamp the row and set the flag.
// ----------------------------------------------------------------------------
module lat_long_to_map_tile_top import llmt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // latitude[29:0], longitude[60:30], zoom[65:61]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // tile_column[23:0], tile_row[47:24]
  output logic [0:0]             m_tuser    // row_saturated[0]
);

  localparam logic signed [LAT_W:0]   LAT_LIM = (LAT_W + 1)'(64'd90 << FRAC_BITS);
  localparam logic signed [LON_W+1:0] LON_OFS = (LON_W + 2)'(64'd180 << FRAC_BITS);
  localparam logic signed [LON_W+1:0] COL_DS  = (LON_W + 2)'(COL_D);
  localparam logic signed [CW-1:0]    ROW_DS  = CW'(ROW_D);

  logic en;

  // ---------------- front stage: decode, column offset, |lat| ----------------
  logic signed [LAT_W-1:0]  lat;
  logic signed [LON_W-1:0]  lon;
  logic [ZOOM_W-1:0]        zoom, zoom_c;
  logic signed [LAT_W:0]    lat_x, lat_abs;
  logic signed [LON_W+1:0]  s_sum, s_wrap;
  side_t                    a_side_next;
  logic [LA_W-1:0]          la_next;

  always_comb begin
    lat    = signed'(s_tdata[LAT_W-1:0]);
    lon    = signed'(s_tdata[LAT_W+LON_W-1:LAT_W]);
    zoom   = s_tdata[LAT_W+LON_W+ZOOM_W-1:LAT_W+LON_W];
    zoom_c = (zoom > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom;
    lat_x  = (LAT_W + 1)'(lat);
    lat_abs = lat_x[LAT_W] ? -lat_x : lat_x;
    s_sum  = (LON_W + 2)'(lon) + LON_OFS;
    if (s_sum < 0) begin
      s_wrap = s_sum + COL_DS;
    end else if (s_sum >= COL_DS) begin
      s_wrap = s_sum - COL_DS;
    end else begin
      s_wrap = s_sum;
    end
    a_side_next.north = (lat > 0);
    a_side_next.psat  = (lat_x >= LAT_LIM) || (lat_x <= -LAT_LIM);
    a_side_next.zero  = 1'b0;
    a_side_next.zoom  = zoom_c;
    a_side_next.col_r = CR_W'(unsigned'(s_wrap));
    la_next = LA_W'(unsigned'(lat_abs)) << (22 - FRAC_BITS);
  end

  logic            a_vld;
  side_t           a_side;
  logic [LA_W-1:0] a_la;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= a_side_next;
      a_la   <= la_next;
    end
  end

  // ---------------- half-angle in radians: h = |lat| * pi/360 ----------------
  logic [P_W-1:0]       prod_h;
  logic signed [CW-1:0] h_next;
  side_t                b_side_next;
  logic                 b_vld;
  side_t                b_side;
  logic signed [CW-1:0] b_h;

  always_comb begin
    prod_h = P_W'(a_la) * P_W'(HALF_DEG);
    h_next = CW'(prod_h >> 22);
    b_side_next      = a_side;
    b_side_next.zero = (h_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= b_side_next;
      b_h    <= h_next;
    end
  end

  // ---------------- circular CORDIC chain ----------------
  logic  c_v [NIT+2];
  side_t c_s [NIT+2];
  circ_t c_d [NIT+2];

  always_comb begin
    c_v[0]   = b_vld;
    c_s[0]   = b_side;
    c_d[0].x = ONE_Q40;
    c_d[0].y = '0;
    c_d[0].a = b_h;
  end

  for (genvar i = 0; i <= NIT; i++) begin : g_circ
    llmt_circ_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shift    (SH_W'(i)),
      .angle    (atan_q40(i)),
      .vld_in   (c_v[i]),
      .side_in  (c_s[i]),
      .cin      (c_d[i]),
      .vld_out  (c_v[i+1]),
      .side_out (c_s[i+1]),
      .cout     (c_d[i+1])
    );
  end

  // ---------------- X+Y1 and X-Y1, coarse normalization ----------------
  logic signed [CW-1:0] cx, cy, su, sw;
  norm_t                u_next;

  always_comb begin
    cx = c_d[NIT+1].x;
    cy = c_d[NIT+1].y;
    su = cx + cy;
    sw = cx - cy;
    u_next.beyond = (sw <= 0) && !c_s[NIT+1].zero;
    u_next.upos   = (su > 0);
    if (su[WQ+1]) begin
      u_next.vu = unsigned'(su) >> 1;
      u_next.ku = K_W'(WQ + 1);
    end else begin
      u_next.vu = unsigned'(su);
      u_next.ku = K_W'(WQ);
    end
    if (sw[WQ+1]) begin
      u_next.vw = unsigned'(sw) >> 1;
      u_next.kw = K_W'(WQ + 1);
    end else begin
      u_next.vw = unsigned'(sw);
      u_next.kw = K_W'(WQ);
    end
  end

  logic  n_v [NORM_N+1];
  side_t n_s [NORM_N+1];
  norm_t n_d [NORM_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v[0] <= 1'b0;
    end else if (en) begin
      n_v[0] <= c_v[NIT+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0] <= c_s[NIT+1];
      n_d[0] <= u_next;
    end
  end

  // ---------------- leading-zero normalization chain ----------------
  for (genvar j = 0; j < NORM_N; j++) begin : g_norm
    llmt_norm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .amount   (SH_W'(1 << (NORM_N - 1 - j))),
      .vld_in   (n_v[j]),
      .side_in  (n_s[j]),
      .nin      (n_d[j]),
      .vld_out  (n_v[j+1]),
      .side_out (n_s[j+1]),
      .nout     (n_d[j+1])
    );
  end

  // ---------------- hyperbolic vectoring chain ----------------
  logic  h_v [HYP_N+1];
  side_t h_s [HYP_N+1];
  ln_t   h_d [HYP_N+1];

  always_comb begin
    h_v[0]        = n_v[NORM_N];
    h_s[0]        = n_s[NORM_N];
    h_d[0].xu     = signed'(n_d[NORM_N].vu) + ONE_Q40;
    h_d[0].yu     = signed'(n_d[NORM_N].vu) - ONE_Q40;
    h_d[0].zu     = '0;
    h_d[0].xw     = signed'(n_d[NORM_N].vw) + ONE_Q40;
    h_d[0].yw     = signed'(n_d[NORM_N].vw) - ONE_Q40;
    h_d[0].zw     = '0;
    h_d[0].ku     = n_d[NORM_N].ku;
    h_d[0].kw     = n_d[NORM_N].kw;
    h_d[0].beyond = n_d[NORM_N].beyond;
    h_d[0].upos   = n_d[NORM_N].upos;
  end

  for (genvar j = 0; j < HYP_N; j++) begin : g_hyp
    llmt_hyp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shift    (SH_W'(hyp_shift(j))),
      .angle    (atanh_q40(hyp_shift(j))),
      .vld_in   (h_v[j]),
      .side_in  (h_s[j]),
      .hin      (h_d[j]),
      .vld_out  (h_v[j+1]),
      .side_out (h_s[j+1]),
      .hout     (h_d[j+1])
    );
  end

  // ---------------- log difference: exponent part and series part ----------------
  logic signed [K_W:0]  dk;
  logic signed [CW-1:0] zu_f, zw_f;
  logic                 l1_vld;
  side_t                l1_side;
  logic signed [CW-1:0] l1_prod, l1_dz;
  logic                 l1_beyond, l1_upos;

  always_comb begin
    dk   = (K_W + 1)'(h_d[HYP_N].ku) - (K_W + 1)'(h_d[HYP_N].kw);
    zu_f = h_d[HYP_N].zu;
    zw_f = h_d[HYP_N].zw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_vld <= 1'b0;
    end else if (en) begin
      l1_vld <= h_v[HYP_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_side   <= h_s[HYP_N];
      l1_prod   <= dk * LN2_Q40;
      l1_dz     <= (zu_f - zw_f) <<< 1;
      l1_beyond <= h_d[HYP_N].beyond;
      l1_upos   <= h_d[HYP_N].upos;
    end
  end

  // ---------------- Mercator magnitude, clamped at zero ----------------
  logic signed [CW-1:0] mag_sum;
  logic                 l2_vld;
  side_t                l2_side;
  logic signed [CW-1:0] l2_mag;
  logic                 l2_beyond;

  always_comb begin
    mag_sum = l1_prod + l1_dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_vld <= 1'b0;
    end else if (en) begin
      l2_vld <= l1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_side   <= l1_side;
      l2_beyond <= l1_beyond;
      if (l1_side.zero || l1_beyond || !l1_upos || mag_sum < 0) begin
        l2_mag <= '0;
      end else begin
        l2_mag <= mag_sum;
      end
    end
  end

  // ---------------- row numerator and clamping ----------------
  logic signed [CW-1:0] num;
  logic [OUT_W-1:0]     zmask;
  div_t                 d_next;

  always_comb begin
    num   = l2_side.north ? (PI_Q40 - l2_mag) : (PI_Q40 + l2_mag);
    zmask = ~({OUT_W{1'b1}} << l2_side.zoom);
    d_next.col_r   = l2_side.col_r;
    d_next.col_q   = '0;
    d_next.row_r   = RR_W'(unsigned'(num));
    d_next.row_q   = '0;
    d_next.row_fix = 1'b0;
    d_next.sat     = 1'b0;
    priority if (l2_side.psat || l2_beyond) begin
      d_next.row_fix = 1'b1;
      d_next.sat     = 1'b1;
      d_next.row_q   = l2_side.north ? '0 : zmask;
    end else if (num < 0) begin
      d_next.row_fix = 1'b1;
      d_next.sat     = 1'b1;
    end else if (num >= ROW_DS) begin
      d_next.row_fix = 1'b1;
      d_next.sat     = 1'b1;
      d_next.row_q   = zmask;
    end
  end

  logic  d_v [MAX_ZOOM+1];
  side_t d_s [MAX_ZOOM+1];
  div_t  d_d [MAX_ZOOM+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= l2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s[0] <= l2_side;
      d_d[0] <= d_next;
    end
  end

  // ---------------- division chain, one quotient bit per cell ----------------
  for (genvar j = 0; j < MAX_ZOOM; j++) begin : g_div
    llmt_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .step     (ZOOM_W'(j)),
      .vld_in   (d_v[j]),
      .side_in  (d_s[j]),
      .din      (d_d[j]),
      .vld_out  (d_v[j+1]),
      .side_out (d_s[j+1]),
      .dout     (d_d[j+1])
    );
  end

  // ---------------- output register and skid stage ----------------
  logic                   t_vld;
  logic [OUT_TDATA_W-1:0] t_data;
  logic                   t_sat;
  logic                   skid_v;
  logic [OUT_TDATA_W-1:0] skid_data;
  logic                   skid_sat;

  assign t_vld    = d_v[MAX_ZOOM];
  assign t_data   = {d_d[MAX_ZOOM].row_q, d_d[MAX_ZOOM].col_q};
  assign t_sat    = d_d[MAX_ZOOM].sat;
  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else begin
      if (skid_v) begin
        if (m_tready) begin
          m_tvalid <= 1'b1;
          skid_v   <= 1'b0;
        end
      end else if (!m_tvalid || m_tready) begin
        m_tvalid <= t_vld;
      end else if (t_vld) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        m_tuser[0] <= skid_sat;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tdata    <= t_data;
      m_tuser[0] <= t_sat;
    end else begin
      skid_data <= t_data;
      skid_sat  <= t_sat;
    end
  end

endmodule

// File: src/llmt_checker.sv
// ----------------------------------------------------------------------------
// llmt_checker - port-level checks for the map tile converter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module llmt_checker import llmt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [0:0]             m_tuser
);

  // no result leaves the block right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // input backpressure only follows an output stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("s_tready low without a downstream stall");

  // a clamped row is either the top row or the last row of the grid
  a_sat_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[47:24] == '0) || m_tdata[24])
    else $error("saturated row is not an edge row");

endmodule

bind lat_long_to_map_tile_top llmt_checker u_llmt_checker (.*);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the lat/long to map tile converter
// Drives coordinate/zoom transactions with bursty gaps, stalls the output
// side on its own pattern, and compares every tile result against a
// fixed-point predictor of the column, the Mercator row and the clamp flag.
// ----------------------------------------------------------------------------
module tb_top;
  import llmt_pkg::*;

  localparam int LATENCY = 121;
  localparam longint LAT_LIM = 64'sd90 <<< FRAC_BITS;

  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             sat;
  } tile_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;

  tile_t  tiles_due[$];
  int     mismatches;
  int     tiles_seen;
  longint atan_tab[0:NIT];
  longint atanh_tab[0:NIT];
  int     burst_left;
  bit     stall_sender;

  lat_long_to_map_tile_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Arithmetic right shift that floors negatives
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Angle tables, Q60 series sums rounded to Q40
  function automatic void build_angle_tables();
    longint sa;
    longint sh;
    longint t;
    int e;
    atan_tab[0]  = ((longint'(PI_Q60) >>> 2) + (64'sd1 <<< 19)) >>> 20;
    atanh_tab[0] = 0;
    for (int i = 1; i <= NIT; i++) begin
      sa = 0;
      sh = 0;
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          t = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
          sa = (k % 2 == 1) ? sa - t : sa + t;
          sh = sh + t;
        end
      end
      atan_tab[i]  = (sa + (64'sd1 <<< 19)) >>> 20;
      atanh_tab[i] = (sh + (64'sd1 <<< 19)) >>> 20;
    end
  endfunction

  // Natural log in Q40 via normalization and hyperbolic vectoring
  function automatic longint log_q40(longint v);
    int k;
    longint m, x, y, z, dx, dy, ln2;
    int reps;
    ln2 = longint'((LN2_Q64 + (64'd1 << 23)) >> 24);
    k = 0;
    for (int b = 0; b < 64; b++) if (v[b]) k = b;
    m = (k > WQ) ? longint'(64'(v) >> (k - WQ)) : longint'(64'(v) << (WQ - k));
    x = m + (64'sd1 <<< WQ);
    y = m - (64'sd1 <<< WQ);
    z = 0;
    for (int i = 1; i <= NIT; i++) begin
      reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
      for (int r = 0; r < reps; r++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (y >= 0) begin
          x -= dx; y -= dy; z += atanh_tab[i];
        end else begin
          x += dx; y += dy; z -= atanh_tab[i];
        end
      end
    end
    return longint'(k - WQ) * ln2 + 2 * z;
  endfunction

  // Expected tile for one coordinate transaction
  function automatic tile_t predict_tile(logic signed [LAT_W-1:0] lat_in,
                                         logic signed [LON_W-1:0] lon_in,
                                         logic [ZOOM_W-1:0] zoom_in);
    tile_t  res;
    longint lat, lon, pi40, d, half_deg, n, den, q, rem, la, h, mag;
    longint x, y, a, dx, dy, u, w;
    longint unsigned mask, r, qq;
    int z;
    bit north, beyond;
    lat = lat_in;
    lon = lon_in;
    z = (zoom_in > MAX_ZOOM) ? MAX_ZOOM : zoom_in;
    north = lat > 0;
    pi40 = (longint'(PI_Q60) + (64'sd1 <<< 19)) >>> 20;
    d = 2 * pi40;
    half_deg = longint'(PI_Q60 / 64'd360) >>> 20;
    mask = (64'd1 << z) - 1;
    res = '0;
    // column: floored division then wrap
    n = (lon + (64'sd180 <<< FRAC_BITS)) * (64'sd1 <<< z);
    den = 64'sd360 <<< FRAC_BITS;
    q = n / den;
    rem = n % den;
    if (rem < 0) q -= 1;
    res.col = OUT_W'(64'(q) & mask);
    if (lat >= LAT_LIM || lat <= -LAT_LIM) begin
      res.sat = 1'b1;
      res.row = north ? '0 : OUT_W'(mask);
      return res;
    end
    la = (north ? lat : -lat) * (64'sd1 <<< (22 - FRAC_BITS));
    h = (la * half_deg) >>> 22;
    mag = 0;
    beyond = 0;
    if (h != 0) begin
      x = 64'sd1 <<< WQ;
      y = 0;
      a = h;
      for (int i = 0; i <= NIT; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (a >= 0) begin
          x -= dx; y += dy; a -= atan_tab[i];
        end else begin
          x += dx; y -= dy; a += atan_tab[i];
        end
      end
      u = x + y;
      w = x - y;
      if (w <= 0) beyond = 1;
      else if (u > 0) mag = log_q40(u) - log_q40(w);
      if (mag < 0) mag = 0;
    end
    n = north ? pi40 - mag : pi40 + mag;
    if (beyond) begin
      res.sat = 1'b1;
      res.row = north ? '0 : OUT_W'(mask);
    end else if (n < 0) begin
      res.sat = 1'b1;
      res.row = '0;
    end else if (n >= d) begin
      res.sat = 1'b1;
      res.row = OUT_W'(mask);
    end else begin
      r = n;
      qq = 0;
      for (int b = 0; b < z; b++) begin
        r = r << 1;
        qq = qq << 1;
        if (r >= longint'(d)) begin
          r -= d;
          qq |= 1;
        end
      end
      res.row = OUT_W'(qq);
    end
    return res;
  endfunction

  // Send one coordinate transaction; sender bursts with random gaps
  task automatic send_coord(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                            logic [ZOOM_W-1:0] zoom);
    if (stall_sender && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) burst_left = 200;
      if (s_tvalid) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, zoom, lon, lat};
    tiles_due.push_back(predict_tile(lat, lon, zoom));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    go_idle();
    guard = 0;
    while (tiles_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic signed [LAT_W-1:0] rand_lat();
    case ($urandom_range(0, 5))
      0: return LAT_W'($urandom);
      1: return LAT_W'($urandom_range(0, 2 * 377487360) - 377487360);
      2: return LAT_W'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(360000000, 377487360));
      default: return LAT_W'($urandom_range(0, 2 * 358000000) - 358000000);
    endcase
  endfunction

  function automatic logic signed [LON_W-1:0] rand_lon();
    if ($urandom_range(0, 4) == 0) return LON_W'($urandom);
    return LON_W'($urandom_range(0, 2 * 754974720) - 754974720);
  endfunction

  function automatic logic [ZOOM_W-1:0] rand_zoom();
    return ($urandom_range(0, 3) == 0) ? ZOOM_W'($urandom) : ZOOM_W'($urandom_range(0, 24));
  endfunction

  // Field extremes, zoom clamp, poles, equator, wrap of longitude
  task automatic test_directed();
    logic signed [LAT_W-1:0] lats[10];
    lats = '{30'sd0, 30'sd377487360, -30'sd377487360, 30'sd377487359, -30'sd377487359,
             30'sd1, -30'sd1, 30'sd357913941, -30'sd536870912, 30'sd536870911};
    foreach (lats[i]) send_coord(lats[i], LON_W'(i * 75000000 - 754974720), ZOOM_W'(i * 3));
    send_coord(30'sd1000, -31'sd754974720, 5'd0);
    send_coord(-30'sd1000, 31'sd754974720, 5'd24);
    send_coord(30'sd123456789, 31'sd754974719, 5'd25);
    send_coord(-30'sd123456789, -31'sd1073741824, 5'd31);
    send_coord(30'sd200000000, 31'sd1073741823, 5'd24);
    send_coord(30'sd0, 31'sd0, 5'd1);
    send_coord(30'sd360000000, -31'sd1, 5'd16);
    send_coord(-30'sd360000000, 31'sd1, 5'd16);
  endtask

  // Random coordinates under sender gaps and receiver stalls
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_coord(rand_lat(), rand_lon(), rand_zoom());
  endtask

  // Back-to-back stream with no sender gaps
  task automatic test_full_rate(int count);
    stall_sender = 0;
    for (int i = 0; i < count; i++) send_coord(rand_lat(), rand_lon(), rand_zoom());
    stall_sender = 1;
  endtask

  // Receiver stall pattern: mostly ready, with stalls drawn at random on every clock
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else case ($urandom_range(0, 15))
      0, 1, 2: m_tready <= 1'b0;
      3:       m_tready <= ($urandom_range(0, 1) == 0);
      default: m_tready <= 1'b1;
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    tile_t got;
    tile_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.col = m_tdata[OUT_W-1:0];
      got.row = m_tdata[2*OUT_W-1:OUT_W];
      got.sat = m_tuser[0];
      tiles_seen++;
      if (tiles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected tile col=%0d row=%0d sat=%0b",
                                       got.col, got.row, got.sat);
      end else begin
        want = tiles_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: tile %0d exp col=%0d row=%0d sat=%0b got col=%0d row=%0d sat=%0b",
                     tiles_seen, want.col, want.row, want.sat, got.col, got.row, got.sat);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mismatches = 0;
    tiles_seen = 0;
    burst_left = 0;
    stall_sender = 1;
    build_angle_tables();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(900);
    drain();
    test_full_rate(300);
    test_random(730);
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && tiles_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
